// ===== rtl/pppe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pppe_pkg;

  // Command codes carried on s_tuser
  typedef enum logic [1:0] {
    CMD_DISPLAY = 2'd0,
    CMD_SCAN    = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_PT_RD  = 8'b0000_0100,
    ST_CT_RD  = 8'b0000_1000,
    ST_DECIDE = 8'b0001_0000,
    ST_EMIT   = 8'b0010_0000,
    ST_PT_WR  = 8'b0100_0000,
    ST_CT_WR  = 8'b1000_0000
  } state_t;

  // Register word select (paddr[2])
  localparam logic REG_SINGLE_PIXEL = 1'b0;

  // Delay field value that drops the following display word
  localparam logic [8:0] DELAY_SKIP = 9'd511;

  localparam int SPREAD_N = 9;
  localparam logic [3:0] SPREAD_CENTER = 4'd5;
  localparam logic [3:0] SPREAD_LAST   = 4'd8;

  // Offsets: 2'b11 is -1, 2'b01 is +1
  function automatic logic [1:0] spread_dx(input logic [3:0] k);
    logic [1:0] d;
    case (k)
      4'd0, 4'd6, 4'd7: d = 2'b11;
      4'd3, 4'd4, 4'd8: d = 2'b01;
      default:          d = 2'b00;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] spread_dy(input logic [3:0] k);
    logic [1:0] d;
    case (k)
      4'd1, 4'd3, 4'd6: d = 2'b11;
      4'd2, 4'd4, 4'd7: d = 2'b01;
      default:          d = 2'b00;
    endcase
    return d;
  endfunction

  // First spread slot used for an intensity
  function automatic logic [3:0] spread_first(input logic [2:0] inten);
    logic [3:0] f;
    if (inten >= 3'd6)      f = 4'd0;
    else if (inten >= 3'd4) f = 4'd1;
    else if (inten == 3'd3) f = 4'd3;
    else                    f = 4'd5;
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/phosphor_point_persistence_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Handshake          | Payload
// ----------+-----+--------------------+-----------------------------------------
// s_*       | in  | s_tvalid/s_tready  | tuser: cmd; tdata: command word, index,
//           |     |                    |   color row/column, color
// m_*       | out | m_tvalid/m_tready  | tdata: x, y, rgba; tuser: still active;
//           |     |                    |   tlast: final pixel of a scan
// APB       | in  | psel/penable/pwrite| single_pixel_mode at byte address 0
//
// After reset a clearing pass zeroes all 2**(2*COORD_BITS) point store entries
// (1048576 at the default), one entry per cycle, with s_tready low.
// A scan steps through transfer, point read, color read, decide, 9 spread
// slots through the one coordinate adder and write-back (none if already inactive).
// A display word or color load adds a write state; skipped, delay or unknown words do not.
// A stall holds the walk on its slot; a last pixel waits in the result register.
module phosphor_point_persistence_engine_top #(
  parameter int COORD_BITS = 10,
  parameter int MAX_AGE    = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // cmd [1:0]
  input  wire logic [1:0]  s_tuser,
  // command_word [31:0], point_index [51:32], table_intensity [54:52],
  // table_age [62:55], table_color [94:63], zero [95]
  input  wire logic [95:0] s_tdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // pixel_x [9:0], pixel_y [19:10], pixel_rgba [51:20], zero [55:52]
  output logic [55:0]      m_tdata,
  // point_still_active [0]
  output logic [0:0]       m_tuser,
  output logic             m_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int PT_AW    = 2 * COORD_BITS;
  localparam int PT_DEPTH = 1 << PT_AW;
  localparam logic [7:0] AGE_LIMIT = 8'(MAX_AGE);

  pppe_pkg::state_t state;

  // config register
  logic single_pixel_mode;

  // input fields
  pppe_pkg::cmd_t in_cmd;
  logic [31:0]    in_word;
  logic [19:0]    in_index;
  logic [2:0]     in_tint;
  logic [7:0]     in_tage;
  logic [31:0]    in_tcolor;

  // item registers
  logic              skip_next_word;
  logic [PT_AW-1:0]  slot;
  logic [10:0]       ct_waddr;
  logic [31:0]       ct_wdata;
  logic [11:0]       pt_wdata;
  logic              pt_wr_pending;
  logic [11:0]       pt;
  logic [31:0]       rgba;
  logic              drawn;
  logic [8:0]        spread_mask;
  logic [3:0]        k;
  logic [PT_AW-1:0]  clear_cnt;

  // memories
  logic [11:0] pt_mem [PT_DEPTH];
  logic [31:0] ct_mem [2048];
  logic [11:0] pt_rd;
  logic [31:0] ct_rd;
  logic [PT_AW-1:0] pt_addr;
  logic             pt_we;
  logic [11:0]      pt_din;

  // datapath
  logic [COORD_BITS-1:0] px, py, sy, qx, qy;
  logic [1:0]  dx, dy;
  logic [8:0]  mask_calc;
  logic        is_last;
  logic        out_free;
  logic        emit_fire;
  logic        advance;
  logic        accept;
  logic        expired;

  assign in_cmd    = pppe_pkg::cmd_t'(s_tuser);
  assign in_word   = s_tdata[31:0];
  assign in_index  = s_tdata[51:32];
  assign in_tint   = s_tdata[54:52];
  assign in_tage   = s_tdata[62:55];
  assign in_tcolor = s_tdata[94:63];

  assign s_tready = (state == pppe_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // APB: always ready, one register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == pppe_pkg::REG_SINGLE_PIXEL) ?
                  {31'b0, single_pixel_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      single_pixel_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == pppe_pkg::REG_SINGLE_PIXEL) begin
      single_pixel_mode <= pwdata[0];
    end
  end

  // Point store: one address, shared by clear pass, lookup and write-back
  assign pt_addr = (state == pppe_pkg::ST_CLEAR) ? clear_cnt : slot;
  assign pt_we   = (state == pppe_pkg::ST_CLEAR) || (state == pppe_pkg::ST_PT_WR);
  assign pt_din  = (state == pppe_pkg::ST_CLEAR) ? 12'd0 : pt_wdata;

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_addr] <= pt_din;
    end
    pt_rd <= pt_mem[pt_addr];
  end

  // Color table: written by loads, read with {intensity, age} of the point
  // word just read, so the color is ready in ST_DECIDE
  always_ff @(posedge clk) begin
    if (state == pppe_pkg::ST_CT_WR) begin
      ct_mem[ct_waddr] <= ct_wdata;
    end
    ct_rd <= ct_mem[pt_rd[10:0]];
  end

  // Grid coordinates; screen row is flipped
  assign px = slot[PT_AW-1:COORD_BITS];
  assign py = slot[COORD_BITS-1:0];
  assign sy = ~py;

  // Shared coordinate adder, one spread slot per cycle unless the output stalls
  assign dx = pppe_pkg::spread_dx(k);
  assign dy = pppe_pkg::spread_dy(k);
  assign qx = px + {{(COORD_BITS-2){dx[1]}}, dx};
  assign qy = sy + {{(COORD_BITS-2){dy[1]}}, dy};

  // Which spread slots land on screen for this point
  always_comb begin
    logic [3:0] first;
    logic [1:0] ex, ey;
    logic       ok;
    first = pppe_pkg::spread_first(pt[10:8]);
    mask_calc = '0;
    for (int j = 0; j < pppe_pkg::SPREAD_N; j++) begin
      ex = pppe_pkg::spread_dx(4'(j));
      ey = pppe_pkg::spread_dy(4'(j));
      ok = (4'(j) >= first);
      if (ex == 2'b11 && px == '0) ok = 1'b0;
      if (ex == 2'b01 && px == '1) ok = 1'b0;
      if (ey == 2'b11 && sy == '0) ok = 1'b0;
      if (ey == 2'b01 && sy == '1) ok = 1'b0;
      mask_calc[j] = ok;
    end
  end

  // No later slot left to draw
  always_comb begin
    is_last = 1'b1;
    for (int j = 0; j < pppe_pkg::SPREAD_N; j++) begin
      if (4'(j) > k && spread_mask[j]) is_last = 1'b0;
    end
  end

  assign expired   = (ct_rd == 32'd0) || (pt[7:0] >= AGE_LIMIT);
  assign out_free  = !m_tvalid || m_tready;
  assign emit_fire = (state == pppe_pkg::ST_EMIT) && spread_mask[k] && out_free;
  assign advance   = (state == pppe_pkg::ST_EMIT) && (!spread_mask[k] || out_free);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= pppe_pkg::ST_CLEAR;
      clear_cnt      <= '0;
      skip_next_word <= 1'b0;
      pt_wr_pending  <= 1'b0;
      k              <= '0;
    end else begin
      unique case (state)
        pppe_pkg::ST_CLEAR: begin
          clear_cnt <= clear_cnt + 1'b1;
          if (clear_cnt == '1) state <= pppe_pkg::ST_IDLE;
        end
        pppe_pkg::ST_IDLE: begin
          if (accept) begin
            unique case (in_cmd)
              pppe_pkg::CMD_DISPLAY: begin
                if (skip_next_word) begin
                  skip_next_word <= 1'b0;
                end else if (in_word[31:23] == pppe_pkg::DELAY_SKIP) begin
                  skip_next_word <= 1'b1;
                end else begin
                  slot     <= {in_word[COORD_BITS-1:0], in_word[10 +: COORD_BITS]};
                  pt_wdata <= {1'b1, in_word[22:20], 8'd0};
                  state    <= pppe_pkg::ST_PT_WR;
                end
              end
              pppe_pkg::CMD_SCAN: begin
                slot  <= in_index[PT_AW-1:0];
                state <= pppe_pkg::ST_PT_RD;
              end
              pppe_pkg::CMD_LOAD: begin
                ct_waddr <= {in_tint, in_tage};
                ct_wdata <= in_tcolor;
                state    <= pppe_pkg::ST_CT_WR;
              end
              pppe_pkg::CMD_NONE: begin
              end
            endcase
          end
        end
        pppe_pkg::ST_PT_RD: begin
          state <= pppe_pkg::ST_CT_RD;
        end
        pppe_pkg::ST_CT_RD: begin
          pt    <= pt_rd;
          state <= pppe_pkg::ST_DECIDE;
        end
        pppe_pkg::ST_DECIDE: begin
          k <= '0;
          if (pt[11] && !expired) begin
            drawn         <= 1'b1;
            rgba          <= ct_rd;
            spread_mask   <= single_pixel_mode ? 9'(1 << pppe_pkg::SPREAD_CENTER)
                                               : mask_calc;
            pt_wdata      <= {1'b1, pt[10:8], pt[7:0] + 8'd1};
            pt_wr_pending <= 1'b1;
          end else begin
            // inactive or expired: one clear pixel at the point itself
            drawn         <= 1'b0;
            rgba          <= 32'd0;
            spread_mask   <= 9'(1 << pppe_pkg::SPREAD_CENTER);
            pt_wdata      <= 12'd0;
            pt_wr_pending <= pt[11];
          end
          state <= pppe_pkg::ST_EMIT;
        end
        pppe_pkg::ST_EMIT: begin
          if (advance) begin
            k <= k + 4'd1;
            if (k == pppe_pkg::SPREAD_LAST) begin
              state <= pt_wr_pending ? pppe_pkg::ST_PT_WR : pppe_pkg::ST_IDLE;
            end
          end
        end
        pppe_pkg::ST_PT_WR: begin
          pt_wr_pending <= 1'b0;
          state         <= pppe_pkg::ST_IDLE;
        end
        pppe_pkg::ST_CT_WR: begin
          state <= pppe_pkg::ST_IDLE;
        end
        default: begin
          state <= pppe_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_tdata    <= {4'd0, rgba, 10'(qy), 10'(qx)};
      m_tuser[0] <= drawn;
      m_tlast    <= is_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pppe_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pppe_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic [1:0]  s_tuser,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [55:0] m_tdata,
  input wire logic [0:0]  m_tuser,
  input wire logic        m_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready
);

  // pending result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // a cleared pixel is the only result of its scan and is black
  a_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[51:20] == 32'd0)
    else $error("clear pixel not single or not black");

  // drawn pixels are never black
  a_drawn: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[51:20] != 32'd0)
    else $error("drawn pixel is black");

  // one transfer at a time: busy after each accepted scan
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == pppe_pkg::CMD_SCAN |=> !s_tready)
    else $error("scan accepted back to back");

endmodule

bind phosphor_point_persistence_engine_top pppe_checker u_pppe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tuser  (s_tuser),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  // Short age limit so that points burn out within a run of ordinary length
  localparam int AGE_LIMIT = 15;
  // Clearing pass after reset zeroes all 2**20 point entries with nothing moving
  localparam int QUIET_LIMIT = 4_500_000;
  localparam int SETTLE = 40;

  localparam int BEAM_DX [9] = '{-1, 0, 0, 1, 1, 0, -1, -1, 1};
  localparam int BEAM_DY [9] = '{0, -1, 1, -1, 1, 0, -1, 1, 0};

  typedef struct packed {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [31:0] rgba;
    logic        live;
    logic        last;
  } pixel_t;

  // Mirrors the point grid, the color table and the skip flag; keeps the
  // pixel writes still owed by the block, oldest first.
  class plot_tracker;
    int          max_age;
    logic [11:0] pts [logic [19:0]];
    logic [31:0] shade [2048];
    bit          filled [2048];
    bit          skip_word;
    bit          spot_mode;
    pixel_t      pending_pixels [$];
    int          errors;
    int          pixels_seen;
    int          scans;
    int          loads;
    int          skips;
    int          expired;

    function new(int age_limit);
      max_age = age_limit;
      skip_word = 1'b0;
      spot_mode = 1'b0;
      foreach (filled[i]) filled[i] = 1'b0;
      errors = 0;
      pixels_seen = 0;
      scans = 0;
      loads = 0;
      skips = 0;
      expired = 0;
    endfunction

    function logic [11:0] point_at(logic [19:0] idx);
      return pts.exists(idx) ? pts[idx] : 12'h000;
    endfunction

    // An active point whose color entry for its intensity and age is unset
    function bit shade_missing(logic [19:0] idx, output logic [10:0] addr);
      logic [11:0] p;
      p = point_at(idx);
      addr = p[10:0];
      return p[11] && !filled[p[10:0]];
    endfunction

    function void push_pixel(int x, int y, logic [31:0] c, logic live);
      pixel_t e;
      e.x = x[9:0];
      e.y = y[9:0];
      e.rgba = c;
      e.live = live;
      e.last = 1'b0;
      pending_pixels.push_back(e);
    endfunction

    function void take_item(pppe_pkg::cmd_t c, logic [95:0] d);
      logic [31:0] w;
      logic [19:0] idx;
      logic [9:0]  px;
      logic [9:0]  sy;
      logic [11:0] p;
      logic [31:0] tone;
      int          first;
      int          qx;
      int          qy;
      pixel_t      e;
      case (c)
        pppe_pkg::CMD_DISPLAY: begin
          w = d[31:0];
          if (skip_word) begin
            skip_word = 1'b0;
          end else if (w[31:23] == pppe_pkg::DELAY_SKIP) begin
            skip_word = 1'b1;
            skips++;
          end else begin
            pts[{w[9:0], w[19:10]}] = {1'b1, w[22:20], 8'd0};
          end
        end
        pppe_pkg::CMD_LOAD: begin
          shade[{d[54:52], d[62:55]}] = d[94:63];
          filled[{d[54:52], d[62:55]}] = 1'b1;
          loads++;
        end
        pppe_pkg::CMD_SCAN: begin
          scans++;
          idx = d[51:32];
          px = idx[19:10];
          sy = ~idx[9:0];
          p = point_at(idx);
          if (!p[11]) begin
            push_pixel(px, sy, 32'd0, 1'b0);
          end else begin
            tone = shade[p[10:0]];
            if (tone == 32'd0 || p[7:0] >= max_age) begin
              pts[idx] = 12'h000;
              expired++;
              push_pixel(px, sy, 32'd0, 1'b0);
            end else begin
              if (spot_mode) begin
                push_pixel(px, sy, tone, 1'b1);
              end else begin
                if (p[10:8] >= 3'd6) first = 0;
                else if (p[10:8] >= 3'd4) first = 1;
                else if (p[10:8] == 3'd3) first = 3;
                else first = 5;
                for (int k = first; k < 9; k++) begin
                  qx = int'(px) + BEAM_DX[k];
                  qy = int'(sy) + BEAM_DY[k];
                  if (qx >= 0 && qy >= 0 && qx <= 1023 && qy <= 1023)
                    push_pixel(qx, qy, tone, 1'b1);
                end
              end
              pts[idx] = {1'b1, p[10:8], p[7:0] + 8'd1};
            end
          end
          e = pending_pixels.pop_back();
          e.last = 1'b1;
          pending_pixels.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void match_pixel(logic [55:0] td, logic live, logic last);
      pixel_t e;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel x=%0d y=%0d rgba=%h active=%0b last=%0b",
                 $time, td[9:0], td[19:10], td[51:20], live, last);
        return;
      end
      e = pending_pixels.pop_front();
      pixels_seen++;
      if (td[9:0] !== e.x) begin
        errors++;
        $display("%0t: pixel_x expected %0d actual %0d", $time, e.x, td[9:0]);
      end
      if (td[19:10] !== e.y) begin
        errors++;
        $display("%0t: pixel_y expected %0d actual %0d", $time, e.y, td[19:10]);
      end
      if (td[51:20] !== e.rgba) begin
        errors++;
        $display("%0t: pixel_rgba expected %h actual %h", $time, e.rgba, td[51:20]);
      end
      if (live !== e.live) begin
        errors++;
        $display("%0t: point_still_active expected %0b actual %0b", $time, e.live, live);
      end
      if (last !== e.last) begin
        errors++;
        $display("%0t: last_pixel expected %0b actual %0b", $time, e.last, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [1:0]  s_tuser = pppe_pkg::CMD_NONE;
  // command_word [31:0], point_index [51:32], table_intensity [54:52],
  // table_age [62:55], table_color [94:63], zero [95]
  logic [95:0] s_tdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // pixel_x [9:0], pixel_y [19:10], pixel_rgba [51:20], zero [55:52]
  logic [55:0] m_tdata;
  // point_still_active [0]
  logic [0:0]  m_tuser;
  logic        m_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  plot_tracker book;
  int          burst_left = 0;
  int          quiet = 0;
  logic [15:0] rdy_pat = 16'hFFFF;
  logic [5:0]  rdy_cnt = '0;
  logic [19:0] pool [10];

  phosphor_point_persistence_engine_top #(
    .MAX_AGE(AGE_LIMIT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: a fresh 16-bit ready pattern each time the 6-bit counter wraps, often all ready
  always @(posedge clk) begin
    rdy_cnt <= rdy_cnt + 6'd1;
    if (rdy_cnt == 6'd0)
      rdy_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    m_tready <= rdy_pat[rdy_cnt[3:0]];
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      book.match_pixel(m_tdata, m_tuser[0], m_tlast);
  end

  // Watchdog: no transfer on either side for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("%0t: timeout, %0d pixels still owed", $time, book.pending_pixels.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [95:0] pack_fields(logic [31:0] cw, logic [19:0] idx,
                                              logic [2:0] ti, logic [7:0] ta,
                                              logic [31:0] col);
    return {1'b0, col, ta, ti, idx, cw};
  endfunction

  function automatic logic [19:0] at(int x, int y);
    return {x[9:0], y[9:0]};
  endfunction

  // One transfer on the input side; sender runs in bursts with gaps between
  task automatic offer(pppe_pkg::cmd_t c, logic [95:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 10);
    end
    burst_left--;
    s_tuser <= c;
    s_tdata <= d;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    book.take_item(c, d);
  endtask

  task automatic load_shade(logic [10:0] addr, logic [31:0] col);
    offer(pppe_pkg::CMD_LOAD, pack_fields($urandom, 20'($urandom), addr[10:8], addr[7:0],
                                          col));
  endtask

  task automatic plot(int x, int y, logic [2:0] inten, logic [8:0] dly);
    offer(pppe_pkg::CMD_DISPLAY, pack_fields({dly, inten, y[9:0], x[9:0]}, 20'($urandom),
                                             3'($urandom), 8'($urandom), $urandom));
  endtask

  // Any unset color entry the scan will read gets loaded first
  task automatic scan(logic [19:0] idx);
    logic [10:0] a;
    if (book.shade_missing(idx, a))
      load_shade(a, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 32'hFFFFFFFF));
    offer(pppe_pkg::CMD_SCAN, pack_fields($urandom, idx, 3'($urandom), 8'($urandom),
                                          $urandom));
  endtask

  // Hold the sender until every owed pixel is out, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (book.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_spot_mode(bit v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {pppe_pkg::REG_SINGLE_PIXEL, 2'b00};
    pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    book.spot_mode = v;
  endtask

  task automatic rand_run(int n);
    int          r;
    logic [19:0] p;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 && $urandom_range(0, 1) == 0) drain();
      r = $urandom_range(0, 99);
      p = pool[$urandom_range(0, 9)];
      if (r < 35) begin
        scan(p);
      end else if (r < 55) begin
        plot(p[19:10], p[9:0], 3'($urandom_range(0, 7)), 9'($urandom_range(0, 510)));
      end else if (r < 62) begin
        // skip word, maybe a scan in between, then the word that gets dropped
        plot($urandom_range(0, 1023), $urandom_range(0, 1023), 3'($urandom_range(0, 7)),
             pppe_pkg::DELAY_SKIP);
        if ($urandom_range(0, 1) == 0) scan(pool[$urandom_range(0, 9)]);
        plot(p[19:10], p[9:0], 3'($urandom_range(0, 7)), 9'($urandom_range(0, 510)));
      end else if (r < 72) begin
        load_shade(11'($urandom_range(0, 2047)),
                   ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom);
      end else if (r < 82) begin
        scan(20'($urandom_range(0, 20'hFFFFF)));
      end else if (r < 90) begin
        offer(pppe_pkg::CMD_DISPLAY, pack_fields($urandom, 20'($urandom), 3'($urandom),
                                                 8'($urandom), $urandom));
      end else if (r < 94) begin
        offer(pppe_pkg::CMD_NONE, pack_fields($urandom, 20'($urandom), 3'($urandom),
                                              8'($urandom), $urandom));
      end else begin
        scan(p);
      end
    end
  endtask

  initial begin
    book = new(AGE_LIMIT);
    pool[0] = at(0, 0);
    pool[1] = at(1023, 1023);
    pool[2] = at(0, 1023);
    pool[3] = at(1023, 0);
    pool[4] = at(0, 500);
    pool[5] = at(1023, 500);
    pool[6] = at(500, 0);
    pool[7] = at(500, 1023);
    pool[8] = 20'($urandom_range(0, 20'hFFFFF));
    pool[9] = 20'($urandom_range(0, 20'hFFFFF));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // point store clearing pass holds s_tready low
    do @(posedge clk); while (!s_tready);

    write_spot_mode(1'b0);

    // beam spread per intensity class, at the grid corners and inside
    plot(0, 0, 3'd7, 9'd0);
    plot(1023, 1023, 3'd6, 9'd0);
    plot(1023, 0, 3'd3, 9'd0);
    plot(512, 300, 3'd4, 9'd0);
    plot(5, 5, 3'd2, 9'h1AA);          // nonzero delay is still plotted
    scan(at(0, 0));
    scan(at(1023, 1023));
    scan(at(1023, 0));
    scan(at(512, 300));
    scan(at(5, 5));
    // skip word survives a scan and a load, then eats the next display word
    plot(7, 7, 3'd5, pppe_pkg::DELAY_SKIP);
    scan(at(5, 5));
    load_shade({3'd7, 8'd200}, 32'hFFFFFFFF);
    plot(9, 9, 3'd7, 9'd0);
    scan(at(9, 9));
    // black color entry kills the point, after which it reads as inactive
    load_shade({3'd2, 8'd2}, 32'd0);
    scan(at(5, 5));
    scan(at(5, 5));
    offer(pppe_pkg::CMD_NONE, pack_fields($urandom, at(0, 0), 3'($urandom), 8'($urandom),
                                          $urandom));
    scan(at(0, 0));

    rand_run(25);
    drain();
    write_spot_mode(1'b1);
    scan(at(512, 300));
    scan(at(1023, 1023));
    rand_run(20);
    drain();
    write_spot_mode(1'b0);
    rand_run(20);
    drain();

    $display("run: %0d scans, %0d pixels compared, %0d color loads, %0d skip words",
             book.scans, book.pixels_seen, book.loads, book.skips);
    $display("run: %0d points expired, single-pixel mode off and on, %0d mismatches",
             book.expired, book.errors);
    if (book.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pppe_pkg.sv
rtl/phosphor_point_persistence_engine_top.sv
rtl/pppe_checker.sv
tb/tb.sv
